@@ rtl/core/lfsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the lowest free slot allocator.
package lfsa_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int TIME_WIDTH = 32;
  localparam int IN_TIME_W  = 32;
  localparam int COUNT_W    = 16;
  localparam int IDX_W      = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_W-1:0]    count;
    logic [TIME_WIDTH-1:0] arrive;
    logic [TIME_WIDTH-1:0] depart;
  } token_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot_index;
    logic [COUNT_W-1:0] use_count;
    logic               full_res;
  } result_t;

endpackage

@@ rtl/core/lfsa_in_if.sv @@
`timescale 1ns / 1ps
// Request channel interface of the allocator.
interface lfsa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [lfsa_pkg::IN_TIME_W-1:0]  arrive_time;
  logic [lfsa_pkg::IN_TIME_W-1:0]  depart_time;

  modport source (output valid, output operation, output arrive_time, output depart_time,
                  input ready);
  modport sink (input valid, input operation, input arrive_time, input depart_time,
                output ready);
endinterface

@@ rtl/core/lfsa_out_if.sv @@
`timescale 1ns / 1ps
// Result channel interface of the allocator.
interface lfsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [lfsa_pkg::IDX_W-1:0]    slot_index;
  logic [lfsa_pkg::COUNT_W-1:0]  use_count;
  logic                          full_res;

  modport source (output valid, output slot_index, output use_count, output full_res,
                  input ready);
  modport sink (input valid, input slot_index, input use_count, input full_res,
                output ready);
endinterface

@@ rtl/core/lfsa_cell.sv @@
`timescale 1ns / 1ps
// One slot of the allocator chain: slot state and one token stage.
module lfsa_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic [lfsa_pkg::IDX_W-1:0]  cell_id,
  input  lfsa_pkg::token_t            tok_in,
  output lfsa_pkg::token_t            tok_out
);

  logic                            valid_r;
  logic [lfsa_pkg::TIME_WIDTH-1:0] busy_until_r;
  logic [lfsa_pkg::COUNT_W-1:0]    count_r;
  logic [lfsa_pkg::COUNT_W-1:0]    count_nxt;
  lfsa_pkg::token_t                tok_r;
  lfsa_pkg::token_t                tok_nxt;
  logic                            free;
  logic                            claim;

  assign free  = !valid_r || (busy_until_r < tok_in.arrive);
  assign claim = tok_in.valid && !tok_in.done && free;
  assign count_nxt = (count_r == lfsa_pkg::COUNT_MAX) ? count_r
                                                      : count_r + 1'b1;

  always_comb begin
    tok_nxt = tok_in;
    if (claim) begin
      tok_nxt.done  = 1'b1;
      tok_nxt.idx   = cell_id;
      tok_nxt.count = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else if (claim) begin
      valid_r <= 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      busy_until_r <= tok_in.depart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ rtl/core/lfsa_ctrl.sv @@
`timescale 1ns / 1ps
// Request intake, chain head injection and the result output stage with skid.
module lfsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  lfsa_in_if.sink           in_ch,
  lfsa_out_if.source        out_ch,
  output lfsa_pkg::token_t  head_tok,
  output logic              clear_all,
  input  lfsa_pkg::token_t  tail_tok
);

  logic              in_fire;
  logic              out_fire;
  logic              busy_r;
  logic              clr_res_r;
  logic              res_vld;
  lfsa_pkg::result_t res;
  lfsa_pkg::result_t out_r;
  lfsa_pkg::result_t skid_r;
  logic              out_v_r;
  logic              skid_v_r;

  assign in_ch.ready = rst_n && !busy_r && !skid_v_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign clear_all   = in_fire && (in_ch.operation == lfsa_pkg::OP_CLEAR);

  always_comb begin
    head_tok        = '0;
    head_tok.valid  = in_fire && (in_ch.operation == lfsa_pkg::OP_ALLOC);
    head_tok.arrive = lfsa_pkg::TIME_WIDTH'(in_ch.arrive_time);
    head_tok.depart = lfsa_pkg::TIME_WIDTH'(in_ch.depart_time);
  end

  assign res_vld = tail_tok.valid || clr_res_r;

  always_comb begin
    res = '0;
    if (!clr_res_r) begin
      if (tail_tok.done) begin
        res.slot_index = tail_tok.idx;
        res.use_count  = tail_tok.count;
      end else begin
        res.full_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      clr_res_r <= 1'b0;
    end else begin
      clr_res_r <= clear_all;
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (res_vld) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_fire = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r) begin
      if (res_vld) begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (!res_vld) begin
        out_v_r <= 1'b0;
      end
    end else if (res_vld) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_fire) begin
      if (out_v_r && skid_v_r) begin
        out_r <= skid_r;
      end else if (res_vld) begin
        out_r <= res;
      end
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.slot_index = out_r.slot_index;
  assign out_ch.use_count  = out_r.use_count;
  assign out_ch.full_res   = out_r.full_res;

endmodule

@@ rtl/core/lowest_free_slot_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the lowest free slot allocator: controller and the chain of slot cells.
//
// Requests arrive on in_ch as valid/ready transactions carrying an operation,
// an arrival time and a departure time; every request yields exactly one
// transaction on out_ch with the slot index, its new use count and a full flag.
// An allocate request is injected at the head of a chain of NUM_SLOTS cells and
// moves one cell per cycle; the first free cell it passes claims it. The result
// reaches the controller once the token has passed all NUM_SLOTS cell registers,
// and no new request is accepted before it is in. A clear empties every cell
// together; its result is registered in clr_res_r and then in the output stage.
// Only one request is in flight at a time; in_ch.ready drops while it is.
// The output register and a skid register let a request be accepted while an
// earlier result still waits; a stalled receiver holds out_ch steady, and once
// both registers are occupied in_ch.ready stays low.
// Reset clears all slots, counts and pending results.
module lowest_free_slot_allocator (
  input  logic        clk,
  input  logic        rst_n,
  lfsa_in_if.sink     in_ch,
  lfsa_out_if.source  out_ch
);

  lfsa_pkg::token_t chain [lfsa_pkg::NUM_SLOTS+1];
  logic             clear_all;

  lfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .head_tok  (chain[0]),
    .clear_all (clear_all),
    .tail_tok  (chain[lfsa_pkg::NUM_SLOTS])
  );

  for (genvar k = 0; k < lfsa_pkg::NUM_SLOTS; k++) begin : g_cell
    lfsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (clear_all),
      .cell_id (lfsa_pkg::IDX_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

endmodule

@@ rtl/core/lfsa_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions of the allocator and their bind to the top level.
module lfsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lfsa_pkg::IDX_W-1:0]  out_slot,
  input logic [lfsa_pkg::COUNT_W-1:0] out_count,
  input logic                        out_full
);

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_count)
                                && $stable(out_full))
    else $error("stalled result changed");

  // A full result assigns nothing.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full |-> out_slot == '0 && out_count == '0)
    else $error("full result carries a slot or count");

  // Only one request is in flight, so an accepted one blocks the next cycle.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // Reset leaves no pending result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_slot  (out_ch.slot_index),
  .out_count (out_ch.use_count),
  .out_full  (out_ch.full_res)
);

@@ bench/slot_alloc_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts each allocator result and compares it with the one delivered.
module slot_alloc_checker (
  input  logic clk,
  input  logic rst_n,
  lfsa_in_if   req,
  lfsa_out_if  res,
  output int   errors,
  output int   pending
);

  logic [lfsa_pkg::TIME_WIDTH-1:0] busy_until [lfsa_pkg::NUM_SLOTS];
  logic                            slot_taken [lfsa_pkg::NUM_SLOTS];
  logic [lfsa_pkg::COUNT_W-1:0]    served     [lfsa_pkg::NUM_SLOTS];
  lfsa_pkg::result_t               pending_grants [$];
  int                              fail_count = 0;
  int                              backlog = 0;

  assign errors  = fail_count;
  assign pending = backlog;

  function automatic lfsa_pkg::result_t serve_request(
    input logic                            op,
    input logic [lfsa_pkg::TIME_WIDTH-1:0] arr,
    input logic [lfsa_pkg::TIME_WIDTH-1:0] dep);
    lfsa_pkg::result_t grant = '0;
    if (op == lfsa_pkg::OP_CLEAR) begin
      for (int k = 0; k < lfsa_pkg::NUM_SLOTS; k++) begin
        busy_until[k] = '0;
        slot_taken[k] = 1'b0;
        served[k]     = '0;
      end
      return grant;
    end
    for (int k = 0; k < lfsa_pkg::NUM_SLOTS; k++) begin
      if (!slot_taken[k] || busy_until[k] < arr) begin
        slot_taken[k] = 1'b1;
        busy_until[k] = dep;
        if (served[k] != lfsa_pkg::COUNT_MAX) served[k] = served[k] + 1'b1;
        grant.slot_index = lfsa_pkg::IDX_W'(k);
        grant.use_count  = served[k];
        return grant;
      end
    end
    grant.full_res = 1'b1;
    return grant;
  endfunction

  always @(posedge clk) begin
    lfsa_pkg::result_t want;
    if (!rst_n) begin
      void'(serve_request(lfsa_pkg::OP_CLEAR, '0, '0));
      pending_grants.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (pending_grants.size() == 0) begin
          $error("result transaction with nothing expected: %0d %0d %0d",
                 res.slot_index, res.use_count, res.full_res);
          fail_count++;
        end else begin
          want = pending_grants.pop_front();
          if (res.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, res.slot_index);
            fail_count++;
          end
          if (res.use_count !== want.use_count) begin
            $error("use_count: expected %0d, got %0d", want.use_count, res.use_count);
            fail_count++;
          end
          if (res.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, res.full_res);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_grants.push_back(serve_request(req.operation,
                                               lfsa_pkg::TIME_WIDTH'(req.arrive_time),
                                               lfsa_pkg::TIME_WIDTH'(req.depart_time)));
      end
    end
    backlog <= pending_grants.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and stall generation, and the verdict.
module tb;

  logic                           clk;
  logic                           rst_n;
  int                             errors;
  int                             pending;
  int                             sent = 0;
  int                             burst_left = 0;
  logic [lfsa_pkg::IN_TIME_W-1:0] now = '0;

  lfsa_in_if  in_ch ();
  lfsa_out_if out_ch ();

  lowest_free_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  slot_alloc_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_ch),
    .res     (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [15:0] ready_pattern;
    int          span;
    out_ch.ready <= 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'($urandom & $urandom);
      endcase
      span = $urandom_range(2, 12);
      repeat (span) begin
        for (int b = 0; b < 16; b++) begin
          @(posedge clk);
          out_ch.ready <= ready_pattern[b];
        end
      end
    end
  end

  task automatic send_req(input logic op, input logic [lfsa_pkg::IN_TIME_W-1:0] arr,
                          input logic [lfsa_pkg::IN_TIME_W-1:0] dep);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.arrive_time <= arr;
    in_ch.depart_time <= dep;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int kind;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= lfsa_pkg::OP_ALLOC;
    in_ch.arrive_time <= '0;
    in_ch.depart_time <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A departure equal to the next arrival keeps the slot busy; an earlier arrival
    // is compared as given; a departure before the arrival is stored anyway.
    send_req(lfsa_pkg::OP_ALLOC, 32'd0, 32'd0);
    send_req(lfsa_pkg::OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_req(lfsa_pkg::OP_ALLOC, 32'd1, 32'd5);
    send_req(lfsa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_req(lfsa_pkg::OP_ALLOC, 32'd0, 32'd3);
    send_req(lfsa_pkg::OP_ALLOC, 32'd1, 32'd2);
    send_req(lfsa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lfsa_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lfsa_pkg::OP_ALLOC, 32'd0, 32'd0);
    send_req(lfsa_pkg::OP_CLEAR, 32'd0, 32'd0);
    wait_idle();

    while (sent < 1925) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) now = $urandom;
      if (kind < 40) begin
        // Long stays with closely spaced arrivals can fill every slot and reach the full case.
        n = $urandom_range(40, 90);
        repeat (n) begin
          now += $urandom_range(0, 2);
          send_req(lfsa_pkg::OP_ALLOC, now, now + $urandom_range(20, 600));
        end
      end else if (kind < 70) begin
        n = $urandom_range(10, 40);
        repeat (n) begin
          now += $urandom_range(0, 20);
          send_req(lfsa_pkg::OP_ALLOC, now, now + $urandom_range(0, 30) - 32'd3);
        end
      end else if (kind < 85) begin
        n = $urandom_range(5, 20);
        repeat (n) begin
          send_req(($urandom_range(0, 9) == 0) ? lfsa_pkg::OP_CLEAR : lfsa_pkg::OP_ALLOC,
                   $urandom, $urandom);
        end
      end else if (kind < 94) begin
        send_req(lfsa_pkg::OP_CLEAR, $urandom, $urandom);
      end else begin
        wait_idle();
      end
    end

    wait_idle();
    repeat (lfsa_pkg::NUM_SLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
